FILE: rtl/pcmrg_pkg.sv
// Shared types and constants for the pixel channel mask and RMS gray block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package pcmrg_pkg;

   localparam int CHAN_W     = 8;
   localparam int SQR_W      = 2 * CHAN_W;
   localparam int SUM_W      = SQR_W + 2;
   localparam int QUOT_W     = SQR_W;
   localparam int REM_W      = CHAN_W + 2;
   localparam int SQRT_CELLS = QUOT_W / 2;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // floor(x / 3) == (x * DIV3_MUL) >> DIV3_SHIFT for every x below 2**DIV3_SHIFT.
   localparam int DIV3_SHIFT = SUM_W + 1;
   localparam int DIV3_W     = SUM_W;
   localparam logic [DIV3_W-1:0] DIV3_MUL = DIV3_W'(((1 << DIV3_SHIFT) + 2) / 3);

   typedef enum logic [1:0] {
      REG_RED   = 2'd0,
      REG_GREEN = 2'd1,
      REG_BLUE  = 2'd2,
      REG_GRAY  = 2'd3
   } reg_idx_type;

   typedef struct packed {
      logic red;
      logic green;
      logic blue;
      logic gray;
   } cfg_type;

   typedef struct packed {
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
   } pixel_type;

   // Word that travels down the square-root chain.
   typedef struct packed {
      pixel_type         pixel;
      logic [QUOT_W-1:0] rad;
      logic [REM_W-1:0]  rem;
      logic [CHAN_W-1:0] root;
   } sq_type;

endpackage

FILE: rtl/pcmrg_if.sv
// Request and response channel interfaces of the pixel block.
// Depends on pcmrg_pkg for the channel width.
`timescale 1ns / 1ps

interface pcmrg_req_if import pcmrg_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] blue_in;
   logic [CHAN_W-1:0] green_in;
   logic [CHAN_W-1:0] red_in;

   modport source (output valid, blue_in, green_in, red_in, input ready);
   modport sink (input valid, blue_in, green_in, red_in, output ready);
endinterface

interface pcmrg_rsp_if import pcmrg_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] blue_out;
   logic [CHAN_W-1:0] green_out;
   logic [CHAN_W-1:0] red_out;

   modport source (output valid, blue_out, green_out, red_out, input ready);
   modport sink (input valid, blue_out, green_out, red_out, output ready);
endinterface

FILE: rtl/pcmrg_front.sv
// Front end: channel masking, squaring, sum of squares and division by three.
// Three stages with their own valid bits; depends on pcmrg_pkg.
`timescale 1ns / 1ps

module pcmrg_front import pcmrg_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      in_valid,
   output logic      in_ready,
   input  pixel_type in_pixel,
   output logic      out_valid,
   input  logic      out_ready,
   output sq_type    out_data
);

   logic              va_ff, vb_ff, vc_ff;
   logic              ready_a, ready_b, ready_c;
   pixel_type         pix_a_ff, pix_b_ff, pix_c_ff;
   pixel_type         masked_in;
   logic [SQR_W-1:0]  sq_r_ff, sq_g_ff, sq_b_ff;
   logic [SUM_W-1:0]  sum_in, sum_ff;
   logic [2*DIV3_W-1:0] prod_in;
   logic [QUOT_W-1:0] quot_ff;

   assign ready_c  = !vc_ff || out_ready;
   assign ready_b  = !vb_ff || ready_c;
   assign ready_a  = !va_ff || ready_b;
   assign in_ready = ready_a;

   always_comb begin
      masked_in.blue  = cfg.blue  ? in_pixel.blue  : '0;
      masked_in.green = cfg.green ? in_pixel.green : '0;
      masked_in.red   = cfg.red   ? in_pixel.red   : '0;
   end

   assign sum_in  = SUM_W'(sq_r_ff) + SUM_W'(sq_g_ff) + SUM_W'(sq_b_ff);
   assign prod_in = sum_ff * DIV3_MUL;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         if (ready_a) va_ff <= in_valid;
         if (ready_b) vb_ff <= va_ff;
         if (ready_c) vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_a && in_valid) begin
         pix_a_ff <= masked_in;
         sq_r_ff  <= masked_in.red   * masked_in.red;
         sq_g_ff  <= masked_in.green * masked_in.green;
         sq_b_ff  <= masked_in.blue  * masked_in.blue;
      end
      if (ready_b && va_ff) begin
         pix_b_ff <= pix_a_ff;
         sum_ff   <= sum_in;
      end
      if (ready_c && vb_ff) begin
         pix_c_ff <= pix_b_ff;
         quot_ff  <= prod_in[DIV3_SHIFT +: QUOT_W];
      end
   end

   assign out_valid      = vc_ff;
   assign out_data.pixel = pix_c_ff;
   assign out_data.rad   = quot_ff;
   assign out_data.rem   = '0;
   assign out_data.root  = '0;

endmodule

FILE: rtl/pcmrg_sqrt_cell.sv
// One cell of the square-root chain: settles one root bit per pass.
// Takes the top two radicand bits, trial-subtracts, hands the word on; uses pcmrg_pkg.
`timescale 1ns / 1ps

module pcmrg_sqrt_cell import pcmrg_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  logic   in_valid,
   output logic   in_ready,
   input  sq_type in_data,
   output logic   out_valid,
   input  logic   out_ready,
   output sq_type out_data
);

   logic             valid_ff;
   sq_type           data_ff, data_in;
   logic [REM_W-1:0] rem_sh, trial;
   logic             fits;

   assign in_ready = !valid_ff || out_ready;

   // The remainder never exceeds twice the partial root, so the shift keeps every bit.
   assign rem_sh = {in_data.rem[REM_W-3:0], in_data.rad[QUOT_W-1 -: 2]};
   assign trial  = {in_data.root, 2'b01};
   assign fits   = rem_sh >= trial;

   always_comb begin
      data_in       = in_data;
      data_in.rad   = {in_data.rad[QUOT_W-3:0], 2'b00};
      data_in.rem   = fits ? rem_sh - trial : rem_sh;
      data_in.root  = {in_data.root[CHAN_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: rtl/pixel_channel_mask_rms_gray.sv
// Pixel channel mask with root-mean-square gray conversion.
// Path from accept to rsp.valid: 3 front stages, 8 root cells (one bit each), output register.
// Throughput: one request per cycle unless rsp.ready is low; the root chain sets the depth.
// Every stage has its own valid bit, so bubbles are filled while the output is stalled.
// Synchronous active-high reset empties the pipeline and clears all four enable registers.
// Depends on pcmrg_pkg, pcmrg_if, pcmrg_front and pcmrg_sqrt_cell.
`timescale 1ns / 1ps

module pixel_channel_mask_rms_gray import pcmrg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   pcmrg_req_if.sink             req,
   pcmrg_rsp_if.source           rsp,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type     cfg_ff;
   reg_idx_type csr_idx;
   logic        csr_wr;
   logic        csr_bit;
   pixel_type   req_pixel;

   logic        cell_valid [SQRT_CELLS+1];
   logic        cell_ready [SQRT_CELLS+1];
   sq_type      cell_data  [SQRT_CELLS+1];

   logic        out_valid_ff;
   logic        out_load;
   pixel_type   out_pix_ff, out_pix_in;
   sq_type      last;

   // Configuration registers.
   assign csr_pready = 1'b1;
   assign csr_idx    = reg_idx_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_RED:   cfg_ff.red   <= csr_pwdata[0];
            REG_GREEN: cfg_ff.green <= csr_pwdata[0];
            REG_BLUE:  cfg_ff.blue  <= csr_pwdata[0];
            REG_GRAY:  cfg_ff.gray  <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_RED:   csr_bit = cfg_ff.red;
         REG_GREEN: csr_bit = cfg_ff.green;
         REG_BLUE:  csr_bit = cfg_ff.blue;
         REG_GRAY:  csr_bit = cfg_ff.gray;
         default:   csr_bit = 1'b0;
      endcase
      csr_prdata = {{(CSR_DATA_W-1){1'b0}}, csr_bit};
   end

   // Datapath.
   assign req_pixel.blue  = req.blue_in;
   assign req_pixel.green = req.green_in;
   assign req_pixel.red   = req.red_in;

   pcmrg_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .in_pixel  (req_pixel),
      .out_valid (cell_valid[0]),
      .out_ready (cell_ready[0]),
      .out_data  (cell_data[0])
   );

   for (genvar i = 0; i < SQRT_CELLS; i++) begin : g_cell
      pcmrg_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cell_valid[i]),
         .in_ready  (cell_ready[i]),
         .in_data   (cell_data[i]),
         .out_valid (cell_valid[i+1]),
         .out_ready (cell_ready[i+1]),
         .out_data  (cell_data[i+1])
      );
   end

   // Output register.
   assign last                   = cell_data[SQRT_CELLS];
   assign cell_ready[SQRT_CELLS] = !out_valid_ff || rsp.ready;
   assign out_load               = cell_ready[SQRT_CELLS] && cell_valid[SQRT_CELLS];

   always_comb begin
      if (cfg_ff.gray) begin
         out_pix_in.blue  = last.root;
         out_pix_in.green = last.root;
         out_pix_in.red   = last.root;
      end else begin
         out_pix_in = last.pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cell_ready[SQRT_CELLS]) begin
         out_valid_ff <= cell_valid[SQRT_CELLS];
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_pix_ff <= out_pix_in;
      end
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.blue_out  = out_pix_ff.blue;
   assign rsp.green_out = out_pix_ff.green;
   assign rsp.red_out   = out_pix_ff.red;

   // With the output register empty, every stage upstream must be able to move.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff |-> req.ready)
      else $error("request stalled while output register is empty");

   a_gray_equal: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && cfg_ff.gray |->
         rsp.blue_out == rsp.green_out && rsp.green_out == rsp.red_out)
      else $error("gray output channels differ");

   a_mask_red: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !cfg_ff.gray && !cfg_ff.red |-> rsp.red_out == '0)
      else $error("disabled red channel is not zero");

endmodule

FILE: tb/tb.sv
// Self-checking bench for pixel_channel_mask_rms_gray: channel masking and RMS gray output.
// Drives pixels and APB register writes, predicts each output pixel, checks it in order.
// Depends on pcmrg_pkg, pcmrg_if and the pixel_channel_mask_rms_gray top level.
`timescale 1ns / 1ps

module tb;
   import pcmrg_pkg::*;

   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 30;
   localparam int RANDOM_PHASES  = 18;
   localparam int PHASE_ITEMS    = 97;
   localparam int MAX_REPORTS    = 10;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   pcmrg_req_if req_if ();
   pcmrg_rsp_if rsp_if ();

   pixel_channel_mask_rms_gray i_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   cfg_type   lane_cfg;
   pixel_type pending_pixels[$];
   int        mismatch_count;
   int        stray_count;
   int        requests_sent;
   int        pixels_checked;
   int        gray_pixels;
   int        cfg_writes;
   bit        steady;
   bit        hold_request;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // Mostly back-to-back, sometimes a short pause, rarely a long one.
   function automatic int pick_gap();
      int roll;
      if (steady) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 70) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [CHAN_W-1:0] rand_chan();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return '0;
      if (roll == 1) return '1;
      return CHAN_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [CHAN_W-1:0] floor_root(logic [SUM_W-1:0] radicand);
      logic [CHAN_W-1:0] root;
      logic [CHAN_W-1:0] trial;
      root = '0;
      for (int b = CHAN_W - 1; b >= 0; b--) begin
         trial = root | (CHAN_W'(1) << b);
         if ((SUM_W + 2)'(trial) * (SUM_W + 2)'(trial) <= (SUM_W + 2)'(radicand))
            root = trial;
      end
      return root;
   endfunction

   function automatic pixel_type shade_pixel(cfg_type cfg, pixel_type px);
      pixel_type         res;
      logic [SUM_W-1:0]  energy;
      logic [CHAN_W-1:0] level;
      res.blue  = cfg.blue  ? px.blue  : '0;
      res.green = cfg.green ? px.green : '0;
      res.red   = cfg.red   ? px.red   : '0;
      if (cfg.gray) begin
         energy = SUM_W'(res.red) * SUM_W'(res.red) + SUM_W'(res.green) * SUM_W'(res.green)
                + SUM_W'(res.blue) * SUM_W'(res.blue);
         level = floor_root(SUM_W'(energy / 3));
         res = '{blue: level, green: level, red: level};
      end
      return res;
   endfunction

   task automatic note_mismatch(string field, logic [CHAN_W-1:0] want, logic [CHAN_W-1:0] got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
   endtask

   // Output side: back-pressure with random stalls and the occasional long hold.
   initial begin
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left  = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   initial begin
      pixel_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            if (pending_pixels.size() == 0) begin
               stray_count++;
               if (stray_count <= MAX_REPORTS)
                  $display("%0t: pixel out with no request pending", $time);
            end else begin
               want = pending_pixels.pop_front();
               pixels_checked++;
               if (rsp_if.blue_out !== want.blue)
                  note_mismatch("blue", want.blue, rsp_if.blue_out);
               if (rsp_if.green_out !== want.green)
                  note_mismatch("green", want.green, rsp_if.green_out);
               if (rsp_if.red_out !== want.red)
                  note_mismatch("red", want.red, rsp_if.red_out);
            end
         end
      end
   end

   task automatic send_pixel(pixel_type px);
      int gap;
      req_if.blue_in  <= px.blue;
      req_if.green_in <= px.green;
      req_if.red_in   <= px.red;
      req_if.valid    <= 1'b1;
      do @(posedge clock); while (!req_if.ready);
      pending_pixels.push_back(shade_pixel(lane_cfg, px));
      requests_sent++;
      if (lane_cfg.gray) gray_pixels++;
      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_rgb(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g, logic [CHAN_W-1:0] b);
      send_pixel('{blue: b, green: g, red: r});
   endtask

   // Stop offering requests and wait until every pixel in flight has come out.
   task automatic settle();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending_pixels.size() != 0);
   endtask

   // Upper data bits are random; the block must keep only bit 0.
   task automatic csr_write(reg_idx_type idx, logic bit_val);
      logic [CSR_DATA_W-1:0] word;
      word    = $urandom();
      word[0] = bit_val;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= word;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_RED:   lane_cfg.red   = bit_val;
         REG_GREEN: lane_cfg.green = bit_val;
         REG_BLUE:  lane_cfg.blue  = bit_val;
         REG_GRAY:  lane_cfg.gray  = bit_val;
         default: ;
      endcase
      cfg_writes++;
      @(posedge clock);
   endtask

   task automatic apply_cfg(cfg_type cfg);
      settle();
      csr_write(REG_RED, cfg.red);
      csr_write(REG_GREEN, cfg.green);
      csr_write(REG_BLUE, cfg.blue);
      csr_write(REG_GRAY, cfg.gray);
   endtask

   // After reset every channel is disabled and gray mode is off.
   task automatic test_reset_state();
      send_rgb(8'hFF, 8'hFF, 8'hFF);
      send_rgb(8'h55, 8'hAA, 8'h0F);
   endtask

   task automatic test_channel_masks();
      apply_cfg('{red: 1'b1, green: 1'b0, blue: 1'b0, gray: 1'b0});
      send_rgb(8'hFF, 8'hAA, 8'h55);
      send_rgb(8'h55, 8'hFF, 8'hAA);
      apply_cfg('{red: 1'b0, green: 1'b1, blue: 1'b0, gray: 1'b0});
      send_rgb(8'hAA, 8'hFF, 8'h00);
      send_rgb(8'h00, 8'h55, 8'hFF);
      apply_cfg('{red: 1'b0, green: 1'b0, blue: 1'b1, gray: 1'b0});
      send_rgb(8'h00, 8'hAA, 8'hFF);
      send_rgb(8'hFF, 8'h00, 8'h55);
      apply_cfg('{red: 1'b1, green: 1'b1, blue: 1'b1, gray: 1'b0});
      send_rgb(8'hFF, 8'h00, 8'hAA);
      send_rgb(8'h55, 8'hAA, 8'hFF);
   endtask

   task automatic test_gray_mode();
      apply_cfg('{red: 1'b1, green: 1'b1, blue: 1'b1, gray: 1'b1});
      // Equal channels give an exact root; the largest one must still fit in a byte.
      send_rgb(8'hFF, 8'hFF, 8'hFF);
      send_rgb(8'h01, 8'h01, 8'h01);
      send_rgb(8'h00, 8'h00, 8'h00);
      send_rgb(8'h01, 8'h01, 8'h00);
      apply_cfg('{red: 1'b1, green: 1'b0, blue: 1'b0, gray: 1'b1});
      send_rgb(8'hFF, 8'hFF, 8'hFF);
      // With every channel masked the gray level collapses to zero.
      apply_cfg('{red: 1'b0, green: 1'b0, blue: 1'b0, gray: 1'b1});
      send_rgb(8'hFF, 8'hFF, 8'hFF);
   endtask

   // Hold the output long enough for the pipeline to fill and push back on the input.
   task automatic test_backpressure();
      apply_cfg('{red: 1'b1, green: 1'b1, blue: 1'b0, gray: 1'b1});
      steady       = 1'b1;
      hold_request = 1'b1;
      for (int k = 0; k < 48; k++) send_rgb(rand_chan(), rand_chan(), rand_chan());
      steady = 1'b0;
   endtask

   task automatic test_random_stream();
      cfg_type cfg;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: cfg = '{red: 1'b1, green: 1'b1, blue: 1'b1, gray: 1'b1};
            1: cfg = '{red: 1'b0, green: 1'b0, blue: 1'b0, gray: 1'b0};
            2: cfg = '{red: 1'b1, green: 1'b1, blue: 1'b1, gray: 1'b0};
            3: cfg = '{red: 1'b0, green: 1'b0, blue: 1'b0, gray: 1'b1};
            default: cfg = cfg_type'(4'($urandom_range(0, 15)));
         endcase
         apply_cfg(cfg);
         steady = (phase % 5 == 4);
         for (int k = 0; k < PHASE_ITEMS; k++) send_rgb(rand_chan(), rand_chan(), rand_chan());
         steady = 1'b0;
      end
   endtask

   initial begin
      lane_cfg       = '0;
      mismatch_count = 0;
      stray_count    = 0;
      requests_sent  = 0;
      pixels_checked = 0;
      gray_pixels    = 0;
      cfg_writes     = 0;
      steady         = 1'b0;
      hold_request   = 1'b0;
      reset           <= 1'b1;
      req_if.valid    <= 1'b0;
      req_if.blue_in  <= '0;
      req_if.green_in <= '0;
      req_if.red_in   <= '0;
      csr_psel        <= 1'b0;
      csr_penable     <= 1'b0;
      csr_pwrite      <= 1'b0;
      csr_paddr       <= '0;
      csr_pwdata      <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_channel_masks();
      test_gray_mode();
      test_backpressure();
      test_random_stream();

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d pixels (%0d in gray mode), checked %0d, over %0d register writes.",
               requests_sent, gray_pixels, pixels_checked, cfg_writes);
      $display("Mismatched fields: %0d, unexpected pixels: %0d, still pending: %0d.",
               mismatch_count, stray_count, pending_pixels.size());
      if (mismatch_count == 0 && stray_count == 0 && pending_pixels.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
